// ===== hw/rtl/mncp_pkg.sv =====
`timescale 1ns / 1ps

package mncp_pkg;

	localparam int NUM_IFS   = 4;
	localparam int NIBS      = 16;
	localparam int WORD_W    = 64;
	localparam int CNT_W     = 5;
	localparam int LEN_W     = 11;
	localparam int CARRY_W   = 60;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_WORDS = 2'd1;

	localparam logic [WORD_W-1:0] MASK_RESET = {WORD_W{1'b1}};
	localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1024;

	// One accepted sample after compaction: per IF, the selected nibbles
	// packed from bit 0 up with zeros above, and how many there are.
	typedef struct packed {
		logic [NUM_IFS-1:0][WORD_W-1:0] chunk;
		logic [NUM_IFS-1:0][CNT_W-1:0]  cnt;
	} entry_t;

endpackage

// ===== hw/rtl/mncp_front.sv =====
`timescale 1ns / 1ps

module mncp_front import mncp_pkg::*; (
	input  logic [WORD_W-1:0]         channel_mask,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [NUM_IFS*WORD_W-1:0] s_tdata,
	input  logic                      q_full,
	output logic                      q_push,
	output entry_t                    q_data
);

	logic [NIBS-1:0] m16;
	logic [3:0]      pos;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Each selected nibble lands at the slot given by the number of selected
	// nibbles below it in the same IF.
	always_comb begin
		q_data = '0;
		m16    = '0;
		pos    = '0;
		for (int f = 0; f < NUM_IFS; f++) begin
			m16 = channel_mask[f*NIBS +: NIBS];
			q_data.cnt[f] = CNT_W'($countones(m16));
			for (int n = 0; n < NIBS; n++) begin
				pos = 4'($countones(m16 & ((16'd1 << n) - 16'd1)));
				if (m16[n]) begin
					q_data.chunk[f][4*pos +: 4] = s_tdata[f*WORD_W + 4*n +: 4];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/mncp_fifo.sv =====
`timescale 1ns / 1ps

module mncp_fifo import mncp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output logic   full,
	output logic   empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_QW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full     = (count_q == CNT_QW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/mncp_back.sv =====
`timescale 1ns / 1ps

module mncp_back import mncp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              busy,
	input  entry_t            entry,
	output logic              pop,
	input  logic [LEN_W-1:0]  len,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic [0:0]        m_tuser
);

	logic [CARRY_W-1:0] carry_q;
	logic [3:0]         carry_cnt_q;
	logic [LEN_W-1:0]   wip_q;
	logic [1:0]         idx_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               out_end_q;
	logic               out_last_q;

	logic [2*WORD_W-1:0] acc;
	logic [CNT_W:0]      sum;
	logic [CNT_W+1:0]    rem;
	logic [3:0]          new_cnt;
	logic [CARRY_W-1:0]  new_carry;
	logic                emit;
	logic                last_d;
	logic                end_d;
	logic [LEN_W:0]      next_wip;
	logic                advance;

	always_comb begin
		acc  = {{(2*WORD_W-CARRY_W){1'b0}}, carry_q}
			| ({{WORD_W{1'b0}}, entry.chunk[idx_q]} << {carry_cnt_q, 2'b00});
		sum  = {2'b00, carry_cnt_q} + {1'b0, entry.cnt[idx_q]};
		emit = (sum >= (CNT_W+1)'(NIBS));
		if (emit) begin
			new_cnt   = 4'(sum - (CNT_W+1)'(NIBS));
			new_carry = acc[WORD_W +: CARRY_W];
		end else begin
			new_cnt   = sum[3:0];
			new_carry = acc[CARRY_W-1:0];
		end
		// Nibbles still to come from the later IFs of this sample.
		case (idx_q)
			2'd0: rem = (CNT_W+2)'(entry.cnt[1]) + (CNT_W+2)'(entry.cnt[2])
				+ (CNT_W+2)'(entry.cnt[3]);
			2'd1: rem = (CNT_W+2)'(entry.cnt[2]) + (CNT_W+2)'(entry.cnt[3]);
			2'd2: rem = (CNT_W+2)'(entry.cnt[3]);
			default: rem = '0;
		endcase
		last_d   = ((CNT_W+2)'(new_cnt) + rem) < (CNT_W+2)'(NIBS);
		next_wip = {1'b0, wip_q} + (LEN_W+1)'(1);
		end_d    = (next_wip >= {1'b0, len});
	end

	assign advance  = busy && (!emit || !out_valid_q || m_tready);
	assign pop      = advance && (idx_q == 2'd3);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = out_last_q;

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_word_q <= acc[WORD_W-1:0];
			out_end_q  <= end_d;
			out_last_q <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= '0;
			carry_cnt_q <= '0;
			wip_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				carry_q     <= new_carry;
				carry_cnt_q <= new_cnt;
				idx_q       <= idx_q + 2'd1;
				if (emit) begin
					wip_q <= end_d ? '0 : next_wip[LEN_W-1:0];
				end
			end
			if (advance && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_end_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && end_d |=> wip_q == '0)
		else $error("packet end did not clear the word counter");

	a_last_if_marks_run: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && idx_q == 2'd3 |-> last_d)
		else $error("word from the last IF not marked as run end");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && idx_q != 2'd3 |=> idx_q == $past(idx_q) + 2'd1)
		else $error("IF index skipped");

endmodule

// ===== hw/rtl/masked_nibble_channel_packer.sv =====
`timescale 1ns / 1ps

// Masked nibble channel packer.
//
// The s_ channel takes one sample per word: four 64-bit IF frames of sixteen
// 4-bit channels each. The channels picked by channel_mask are packed, in
// ascending channel order, into 64-bit words that leave on the m_ channel.
// m_tlast flags the word that closes a packet of packet_words words, and
// m_tuser flags the last word a sample produced. A sample yields 0 to 4 words.
// The cfg_ channel writes the registers and is always ready; write it only
// while no sample is in flight.
// The front compacts each IF's selected nibbles on acceptance and queues the
// sample; the back merges one IF per cycle into the carry while its output
// is not stalled, and one word can leave per cycle. The first word of a
// sample leaves from the back's output register, after any queue wait.
// Reset clears the carry and the packet word count, sets the mask to all
// channels and the packet length to 1024 words. When the receiver stalls the
// back end holds, the queue fills and s_tready drops.

module masked_nibble_channel_packer import mncp_pkg::*; #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Sample input.
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [NUM_IFS*WORD_W-1:0] s_tdata,  // if0_word, if1_word, if2_word, if3_word
	// Packed output.
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [WORD_W-1:0]         m_tdata,  // packed_word
	output logic                      m_tlast,  // packet_end
	output logic [0:0]                m_tuser,  // run_last
	// Register writes.
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [WORD_W-1:0]         cfg_data
);

	logic [WORD_W-1:0] channel_mask_q;
	logic [LEN_W-1:0]  packet_words_q;
	logic [LEN_W-1:0]  len;

	entry_t push_data;
	entry_t pop_data;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	assign cfg_ready = 1'b1;

	// A length of zero behaves as one word per packet.
	assign len = (packet_words_q == '0) ? LEN_W'(1) : packet_words_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mask_q <= MASK_RESET;
			packet_words_q <= LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHANNEL_MASK: channel_mask_q <= cfg_data;
				CFG_PACKET_WORDS: packet_words_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	mncp_front u_front (
		.channel_mask (channel_mask_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.q_full       (full),
		.q_push       (push),
		.q_data       (push_data)
	);

	mncp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	mncp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.busy     (!empty),
		.entry    (pop_data),
		.pop      (pop),
		.len      (len),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
